/* src/sdw_pkg.sv */
// Shared types, widths and helpers for the stereo disparity WTA block.
// No dependencies; imported by every module under src.
package sdw_pkg;

    localparam int MAX_DISP_DEF = 64;

    localparam int FEAT_W     = 8;
    localparam int WEIGHT_W   = 12;
    localparam int RANGE_W    = 7;
    localparam int SAD_W      = 9;              // sum of two 8-bit absolute differences
    localparam int PROD_W     = WEIGHT_W + SAD_W;
    localparam int COST_W     = PROD_W + 1;
    localparam int DEN_W      = COST_W + 1;
    localparam int NUM_W      = COST_W + 5;     // 16*mag + den
    localparam int QUOT_W     = 4;              // offset never exceeds 8
    localparam int DISP_W     = 12;
    localparam int DISP_EXT_W = DISP_W + 1;
    localparam int WHOLE_W    = 6;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [DISP_EXT_W-1:0] DISP_MAX = DISP_EXT_W'(4080);

    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(256);
    localparam logic [RANGE_W-1:0]  RANGE_RST  = RANGE_W'(64);

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_WEIGHT_GRAD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WEIGHT_DOG  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DISP_RANGE  = 2'd2;

    typedef struct packed {
        logic [FEAT_W-1:0] dog_y;
        logic [FEAT_W-1:0] dog_x;
        logic [FEAT_W-1:0] grad_y;
        logic [FEAT_W-1:0] grad_x;
    } t_feat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PREP,
        ST_LOAD,
        ST_DIV,
        ST_FIN
    } t_state;

    function automatic logic [FEAT_W-1:0] absdiff8(logic [FEAT_W-1:0] a, logic [FEAT_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

endpackage

/* src/sdw_window.sv */
// Circular store of the right-image features of the current row.
// Depends on sdw_pkg. Entry d is the pixel d columns left of the newest one.
module sdw_window #(
    parameter int MAX_DISP = sdw_pkg::MAX_DISP_DEF,
    parameter int DW       = $clog2(MAX_DISP)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sdw_pkg::t_feat  i_push_data,
    input  logic [DW-1:0]   i_rd_d,
    output sdw_pkg::t_feat  o_rd_data
);
    import sdw_pkg::*;

    localparam logic [DW-1:0] PTR_LAST = DW'(MAX_DISP - 1);
    localparam logic [DW:0]   DEPTH    = (DW + 1)'(MAX_DISP);

    t_feat         r_mem [MAX_DISP];
    t_feat         r_rd_data;
    logic [DW-1:0] r_wp;
    logic [DW-1:0] n_wp;
    logic [DW:0]   rd_diff;
    logic [DW:0]   rd_wrap;
    logic [DW-1:0] rd_addr;

    assign n_wp    = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
    assign rd_diff = {1'b0, r_wp} - {1'b0, i_rd_d};
    assign rd_wrap = rd_diff + DEPTH;
    assign rd_addr = rd_diff[DW] ? rd_wrap[DW-1:0] : rd_diff[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (i_push) begin
            r_wp <= n_wp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[n_wp] <= i_push_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/sdw_cost.sv */
// Two-stage matching cost unit: weighted gradient and DoG absolute differences.
// Depends on sdw_pkg. One disparity enters per cycle; products and cost sum are each registered.
module sdw_cost (
    input  logic                          i_clk,
    input  sdw_pkg::t_feat                i_left,
    input  sdw_pkg::t_feat                i_right,
    input  logic [sdw_pkg::WEIGHT_W-1:0]  i_weight_grad,
    input  logic [sdw_pkg::WEIGHT_W-1:0]  i_weight_dog,
    output logic [sdw_pkg::COST_W-1:0]    o_cost
);
    import sdw_pkg::*;

    logic [SAD_W-1:0]  sad_grad;
    logic [SAD_W-1:0]  sad_dog;
    logic [PROD_W-1:0] r_prod_grad;
    logic [PROD_W-1:0] r_prod_dog;
    logic [COST_W-1:0] r_cost;

    assign sad_grad = SAD_W'(absdiff8(i_left.grad_x, i_right.grad_x))
                    + SAD_W'(absdiff8(i_left.grad_y, i_right.grad_y));
    assign sad_dog  = SAD_W'(absdiff8(i_left.dog_x, i_right.dog_x))
                    + SAD_W'(absdiff8(i_left.dog_y, i_right.dog_y));

    always_ff @(posedge i_clk) begin
        r_prod_grad <= PROD_W'(i_weight_grad) * PROD_W'(sad_grad);
        r_prod_dog  <= PROD_W'(i_weight_dog) * PROD_W'(sad_dog);
        r_cost      <= COST_W'(r_prod_grad) + COST_W'(r_prod_dog);
    end

    assign o_cost = r_cost;

endmodule

/* src/sdw_div.sv */
// Restoring divider for the subpixel offset, one quotient bit per cycle.
// Depends on sdw_pkg. The divisor arrives pre-shifted to the top quotient bit.
module sdw_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sdw_pkg::NUM_W-1:0]   i_num,
    input  logic [sdw_pkg::NUM_W-1:0]   i_div_top,
    output logic                        o_done,
    output logic [sdw_pkg::QUOT_W-1:0]  o_quot
);
    import sdw_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);

    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_dsh;
    logic [QUOT_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              ge;

    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= i_div_top;
            r_quot <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quot <= {r_quot[QUOT_W-2:0], ge};
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* src/stereo_disparity_wta_subpixel_top.sv */
// Top level of the WTA stereo disparity block with parabolic subpixel refinement.
// Depends on sdw_pkg, sdw_window, sdw_cost and sdw_div.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------------
//  input    | i_in_valid / o_in_ready     | i_row_start, i_left_*, i_right_*
//  output   | o_out_valid / i_out_ready   | o_disparity (Q8.4), o_whole_disparity
//  config   | i_cfg_we (no back-pressure) | i_cfg_addr, i_cfg_data
//
// An item is scanned over maxd disparities, and the parabola is fitted only when the winner
// has two neighbours; maxd is min(column + 1, range), with the range taken as 1..MAX_DISP.
// The window memory read port sets the scan pace: one disparity per cycle.
// Reset is synchronous, active low, and clears control state only; the window is not
// cleared since only entries written in the current row are ever read.
// A finished result waits in the output register; the next request is taken meanwhile,
// and only the final write-back stalls on a full output register.
module stereo_disparity_wta_subpixel_top #(
    parameter int MAX_DISP = sdw_pkg::MAX_DISP_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_row_start,
    input  logic [sdw_pkg::FEAT_W-1:0]      i_left_grad_x,
    input  logic [sdw_pkg::FEAT_W-1:0]      i_left_grad_y,
    input  logic [sdw_pkg::FEAT_W-1:0]      i_left_dog_x,
    input  logic [sdw_pkg::FEAT_W-1:0]      i_left_dog_y,
    input  logic [sdw_pkg::FEAT_W-1:0]      i_right_grad_x,
    input  logic [sdw_pkg::FEAT_W-1:0]      i_right_grad_y,
    input  logic [sdw_pkg::FEAT_W-1:0]      i_right_dog_x,
    input  logic [sdw_pkg::FEAT_W-1:0]      i_right_dog_y,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [sdw_pkg::DISP_W-1:0]      o_disparity,
    output logic [sdw_pkg::WHOLE_W-1:0]     o_whole_disparity,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [sdw_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [sdw_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sdw_pkg::*;

    localparam int DW = $clog2(MAX_DISP);
    // width able to hold both the range register and MAX_DISP
    localparam int RW = (DW + 1 > RANGE_W) ? DW + 1 : RANGE_W;

    localparam logic [DW-1:0] COL_LAST  = DW'(MAX_DISP - 1);
    localparam logic [RW-1:0] RNG_MAX   = RW'(MAX_DISP);
    localparam logic [RW-1:0] RNG_ONE   = RW'(1);

    // ---------------- configuration ----------------
    logic [WEIGHT_W-1:0] r_weight_grad;
    logic [WEIGHT_W-1:0] r_weight_dog;
    logic [RANGE_W-1:0]  r_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_grad <= WEIGHT_RST;
            r_weight_dog  <= WEIGHT_RST;
            r_range       <= RANGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WEIGHT_GRAD: r_weight_grad <= i_cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_DOG:  r_weight_dog  <= i_cfg_data[WEIGHT_W-1:0];
                CFG_DISP_RANGE:  r_range       <= i_cfg_data[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    t_state r_state;
    t_state n_state;

    logic in_ready;
    logic accept;
    logic issue;
    logic div_start;
    logic out_load;
    logic scan_last;
    logic refine;
    logic div_done;

    logic [DW-1:0] r_rd_d;
    logic [DW:0]   r_maxd;
    logic [DW-1:0] r_col;

    // tag pipeline, aligned with memory read, products, cost
    logic          r_v1, r_v2, r_v3;
    logic          r_l1, r_l2, r_l3;
    logic [DW-1:0] r_d1, r_d2, r_d3;

    assign accept    = i_in_valid && in_ready;
    assign scan_last = ((DW + 1)'(r_rd_d) + 1'b1) == r_maxd;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN:  if (scan_last) n_state = ST_DRAIN;
            ST_DRAIN: if (r_v3 && r_l3) n_state = ST_PREP;
            ST_PREP:  n_state = refine ? ST_LOAD : ST_FIN;
            ST_LOAD:  n_state = ST_DIV;
            ST_DIV:   if (div_done) n_state = ST_FIN;
            ST_FIN:   if (!o_out_valid || i_out_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        issue     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE: in_ready  = 1'b1;
            ST_SCAN: issue     = 1'b1;
            ST_LOAD: div_start = 1'b1;
            ST_FIN:  out_load  = !o_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- item set-up ----------------
    t_feat         r_left;
    t_feat         right_in;
    logic [DW-1:0] col_cur;
    logic [RW-1:0] rng_in;
    logic [RW-1:0] rng_eff;
    logic [RW-1:0] col_plus;
    logic [RW-1:0] maxd_in;

    assign right_in = '{dog_y: i_right_dog_y, dog_x: i_right_dog_x,
                        grad_y: i_right_grad_y, grad_x: i_right_grad_x};

    // no row start after reset still starts at column 0: r_col resets to zero
    assign col_cur  = i_row_start ? '0 : r_col;
    assign rng_in   = RW'(r_range);
    assign rng_eff  = (rng_in == '0) ? RNG_ONE : ((rng_in > RNG_MAX) ? RNG_MAX : rng_in);
    assign col_plus = RW'(col_cur) + RNG_ONE;
    assign maxd_in  = (col_plus < rng_eff) ? col_plus : rng_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_rd_d <= '0;
        end else if (accept) begin
            r_col  <= (col_cur == COL_LAST) ? col_cur : col_cur + 1'b1;
            r_rd_d <= '0;
        end else if (issue) begin
            r_rd_d <= r_rd_d + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left <= '{dog_y: i_left_dog_y, dog_x: i_left_dog_x,
                        grad_y: i_left_grad_y, grad_x: i_left_grad_x};
            r_maxd <= maxd_in[DW:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l1 <= issue && scan_last;
        r_l2 <= r_l1;
        r_l3 <= r_l2;
        r_d1 <= r_rd_d;
        r_d2 <= r_d1;
        r_d3 <= r_d2;
    end

    // ---------------- datapath units ----------------
    t_feat             rd_right;
    logic [COST_W-1:0] cost;

    sdw_window #(
        .MAX_DISP (MAX_DISP),
        .DW       (DW)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_push_data (right_in),
        .i_rd_d      (r_rd_d),
        .o_rd_data   (rd_right)
    );

    sdw_cost u_cost (
        .i_clk         (i_clk),
        .i_left        (r_left),
        .i_right       (rd_right),
        .i_weight_grad (r_weight_grad),
        .i_weight_dog  (r_weight_dog),
        .o_cost        (cost)
    );

    // ---------------- winner tracking ----------------
    // p: cost left of the winner, m: winner cost, n: cost right of the winner
    logic [DW-1:0]     r_best;
    logic [COST_W-1:0] r_p, r_m, r_n, r_prev;
    logic              r_pend;

    always_ff @(posedge i_clk) begin
        if (r_v3) begin
            r_prev <= cost;
            if (r_d3 == '0 || cost < r_m) begin
                // first strict minimum wins, so ties keep the earlier disparity
                r_best <= r_d3;
                r_m    <= cost;
                r_p    <= r_prev;
                r_pend <= 1'b1;
            end else if (r_pend) begin
                r_n    <= cost;
                r_pend <= 1'b0;
            end
        end
    end

    assign refine = (r_best != '0) && (((DW + 1)'(r_best) + 1'b1) < r_maxd);

    // ---------------- subpixel fit ----------------
    logic [DEN_W-1:0]  r_den;
    logic [COST_W-1:0] r_mag;
    logic              r_p_ge_n;
    logic              r_refine;
    logic [NUM_W-1:0]  div_num;
    logic [NUM_W-1:0]  div_top;
    logic [QUOT_W-1:0] quot;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP) begin
            r_den    <= DEN_W'(r_p - r_m) + DEN_W'(r_n - r_m);
            r_mag    <= (r_p > r_n) ? r_p - r_n : r_n - r_p;
            r_p_ge_n <= (r_p >= r_n);
            r_refine <= refine;
        end
    end

    // offset = (16*mag + den) / (2*den); the divisor enters shifted to quotient bit 3
    assign div_num = NUM_W'({r_mag, 4'b0000}) + NUM_W'(r_den);
    assign div_top = NUM_W'({r_den, 4'b0000});

    sdw_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_num     (div_num),
        .i_div_top (div_top),
        .o_done    (div_done),
        .o_quot    (quot)
    );

    // ---------------- result ----------------
    logic [DISP_EXT_W-1:0] disp_base;
    logic [DISP_EXT_W-1:0] disp_off;
    logic [DISP_EXT_W-1:0] disp_sum;
    logic [DISP_EXT_W-1:0] disp_clamp;
    logic                  r_out_valid;
    logic [DISP_W-1:0]     r_disparity;
    logic [WHOLE_W-1:0]    r_whole;

    assign disp_base = DISP_EXT_W'({r_best, 4'b0000});
    assign disp_off  = DISP_EXT_W'(quot);
    // winner is at least 1 when refined, so the subtraction cannot go below zero
    assign disp_sum  = !r_refine ? disp_base :
                       (r_p_ge_n ? disp_base + disp_off : disp_base - disp_off);
    assign disp_clamp = (disp_sum > DISP_MAX) ? DISP_MAX : disp_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_disparity <= disp_clamp[DISP_W-1:0];
            r_whole     <= WHOLE_W'(r_best);
        end
    end

    assign o_in_ready        = in_ready;
    assign o_out_valid       = r_out_valid;
    assign o_disparity       = r_disparity;
    assign o_whole_disparity = r_whole;

    // ---------------- checks ----------------
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((DW + 1)'(r_rd_d) < r_maxd))
        else $error("scan index beyond searched range");

    a_tags_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> !(r_v1 || r_v2 || r_v3))
        else $error("cost pipeline busy while taking a request");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside its wait state");

    a_parabola_convex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREP && refine) |-> (r_p > r_m && r_n >= r_m))
        else $error("winner is not a strict local minimum");

    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (quot <= QUOT_W'(8)))
        else $error("subpixel offset exceeds half a pixel");

endmodule

/* sim/stereo_disparity_wta_subpixel_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for stereo_disparity_wta_subpixel_top: directed cases and random
// pixel rows against a built-in disparity predictor, with random idling on both channels.
// Depends on sdw_pkg and the RTL under src only.
module stereo_disparity_wta_subpixel_top_tb;
    import sdw_pkg::*;

    localparam int          WINDOW_DEPTH = MAX_DISP_DEF;
    localparam int          SETTLE_CYCLES = 90;
    localparam int unsigned CYCLE_LIMIT   = 1000000;

    // one input request: row flag plus left and right features
    typedef struct packed {
        logic  row_start;
        t_feat left;
        t_feat right;
    } t_pixel_pair;

    typedef struct packed {
        logic [DISP_W-1:0]  disparity;
        logic [WHOLE_W-1:0] whole;
    } t_disparity_result;

    // Scoreboard: keeps its own copy of the window, column and registers, predicts the
    // disparity of every accepted request and checks results in order.
    class disparity_scoreboard;
        logic [WEIGHT_W-1:0] grad_weight;
        logic [WEIGHT_W-1:0] dog_weight;
        logic [RANGE_W-1:0]  search_range;
        t_feat               feature_window[WINDOW_DEPTH];
        int unsigned         next_column;
        t_disparity_result   pending_disparities[$];
        int unsigned         request_count;
        int unsigned         result_count;
        int unsigned         error_count;

        function new();
            grad_weight  = WEIGHT_RST;
            dog_weight   = WEIGHT_RST;
            search_range = RANGE_RST;
            next_column  = 0;
            foreach (feature_window[i]) feature_window[i] = '0;
            request_count = 0;
            result_count  = 0;
            error_count   = 0;
        endfunction

        function void write_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                CFG_WEIGHT_GRAD: grad_weight = data[WEIGHT_W-1:0];
                CFG_WEIGHT_DOG:  dog_weight = data[WEIGHT_W-1:0];
                CFG_DISP_RANGE:  search_range = data[RANGE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned abs_gap(logic [FEAT_W-1:0] a, logic [FEAT_W-1:0] b);
            return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        endfunction

        function t_disparity_result predict_disparity(t_pixel_pair px);
            longint unsigned   costs[WINDOW_DEPTH];
            longint unsigned   lower_cost, mid_cost, upper_cost, den, mag, offset;
            int unsigned       col, lim, span, best, d, grad_sad, dog_sad;
            int                disp;
            t_disparity_result res;

            col = px.row_start ? 0 : next_column;
            if (col > WINDOW_DEPTH - 1) col = WINDOW_DEPTH - 1;
            for (d = WINDOW_DEPTH - 1; d > 0; d--) feature_window[d] = feature_window[d-1];
            feature_window[0] = px.right;

            lim = int'(search_range);
            if (lim < 1) lim = 1;
            if (lim > WINDOW_DEPTH) lim = WINDOW_DEPTH;
            span = (col + 1 < lim) ? col + 1 : lim;

            best = 0;
            for (d = 0; d < span; d++) begin
                grad_sad = abs_gap(px.left.grad_x, feature_window[d].grad_x)
                         + abs_gap(px.left.grad_y, feature_window[d].grad_y);
                dog_sad  = abs_gap(px.left.dog_x, feature_window[d].dog_x)
                         + abs_gap(px.left.dog_y, feature_window[d].dog_y);
                costs[d] = longint'(grad_weight) * grad_sad + longint'(dog_weight) * dog_sad;
                if (d == 0 || costs[d] < costs[best]) best = d;
            end

            // parabola through the winner and both neighbours, rounded half away from zero
            disp = best * 16;
            if (best > 0 && best + 1 < span) begin
                lower_cost = costs[best-1];
                mid_cost   = costs[best];
                upper_cost = costs[best+1];
                den = (lower_cost - mid_cost) + (upper_cost - mid_cost);
                mag = (lower_cost > upper_cost) ? lower_cost - upper_cost
                                                : upper_cost - lower_cost;
                offset = 0;
                if (den != 0) offset = (16 * mag + den) / (2 * den);
                if (lower_cost >= upper_cost) disp = disp + int'(offset);
                else disp = disp - int'(offset);
            end
            if (disp < 0) disp = 0;
            if (disp > 4080) disp = 4080;

            res.disparity = disp[DISP_W-1:0];
            res.whole     = best[WHOLE_W-1:0];
            next_column = (col + 1 < WINDOW_DEPTH - 1) ? col + 1 : WINDOW_DEPTH - 1;
            return res;
        endfunction

        function void note_request(t_pixel_pair px);
            pending_disparities.push_back(predict_disparity(px));
            request_count++;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH result %0d: %s", result_count, msg);
            error_count++;
        endtask

        task check_result(logic [DISP_W-1:0] got_disp, logic [WHOLE_W-1:0] got_whole);
            t_disparity_result want;
            if (pending_disparities.size() == 0) begin
                report_mismatch($sformatf("unexpected result disparity=%0d whole=%0d",
                                          got_disp, got_whole));
            end else begin
                want = pending_disparities.pop_front();
                if (got_disp !== want.disparity)
                    report_mismatch($sformatf("disparity got %0d want %0d",
                                              got_disp, want.disparity));
                if (got_whole !== want.whole)
                    report_mismatch($sformatf("whole_disparity got %0d want %0d",
                                              got_whole, want.whole));
            end
            result_count++;
        endtask
    endclass

    // ---------------------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ---------------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_row_start = 1'b0;
    logic [FEAT_W-1:0]     i_left_grad_x = '0;
    logic [FEAT_W-1:0]     i_left_grad_y = '0;
    logic [FEAT_W-1:0]     i_left_dog_x = '0;
    logic [FEAT_W-1:0]     i_left_dog_y = '0;
    logic [FEAT_W-1:0]     i_right_grad_x = '0;
    logic [FEAT_W-1:0]     i_right_grad_y = '0;
    logic [FEAT_W-1:0]     i_right_dog_x = '0;
    logic [FEAT_W-1:0]     i_right_dog_y = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [DISP_W-1:0]     o_disparity;
    logic [WHOLE_W-1:0]    o_whole_disparity;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    disparity_scoreboard board;
    bit                  no_idle = 1'b0;   // set for a phase with back-to-back traffic
    int unsigned         sent_count = 0;

    stereo_disparity_wta_subpixel_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_row_start       (i_row_start),
        .i_left_grad_x     (i_left_grad_x),
        .i_left_grad_y     (i_left_grad_y),
        .i_left_dog_x      (i_left_dog_x),
        .i_left_dog_y      (i_left_dog_y),
        .i_right_grad_x    (i_right_grad_x),
        .i_right_grad_y    (i_right_grad_y),
        .i_right_dog_x     (i_right_dog_x),
        .i_right_dog_y     (i_right_dog_y),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_disparity       (o_disparity),
        .o_whole_disparity (o_whole_disparity),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Idle length for either side: mostly none or short, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned pick;
        if (no_idle) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 88) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_feat flat_feat(logic [FEAT_W-1:0] v);
        return '{dog_y: v, dog_x: v, grad_y: v, grad_x: v};
    endfunction

    function automatic t_feat random_feat();
        t_feat f;
        f.grad_x = FEAT_W'($urandom_range(0, 255));
        f.grad_y = FEAT_W'($urandom_range(0, 255));
        f.dog_x  = FEAT_W'($urandom_range(0, 255));
        f.dog_y  = FEAT_W'($urandom_range(0, 255));
        return f;
    endfunction

    // small saturating disturbance of a matched pixel, so minima are not always exact
    function automatic t_feat jitter_feat(t_feat f, int amt);
        t_feat r;
        int    v[4];
        v[0] = int'(f.grad_x); v[1] = int'(f.grad_y); v[2] = int'(f.dog_x); v[3] = int'(f.dog_y);
        foreach (v[i]) begin
            v[i] = v[i] + $urandom_range(0, 2 * amt) - amt;
            if (v[i] < 0) v[i] = 0;
            if (v[i] > 255) v[i] = 255;
        end
        r.grad_x = FEAT_W'(v[0]);
        r.grad_y = FEAT_W'(v[1]);
        r.dog_x  = FEAT_W'(v[2]);
        r.dog_y  = FEAT_W'(v[3]);
        return r;
    endfunction

    // Present one request and hold it until accepted. Valid is left high on return, so the
    // caller either presents the next request in the same step or lowers valid.
    task automatic send_request(input t_pixel_pair px);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_row_start    <= px.row_start;
        i_left_grad_x  <= px.left.grad_x;
        i_left_grad_y  <= px.left.grad_y;
        i_left_dog_x   <= px.left.dog_x;
        i_left_dog_y   <= px.left.dog_y;
        i_right_grad_x <= px.right.grad_x;
        i_right_grad_y <= px.right.grad_y;
        i_right_dog_x  <= px.right.dog_x;
        i_right_dog_y  <= px.right.dog_y;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_request(px);
        sent_count++;
    endtask

    task automatic send_pixel(input logic rs, input t_feat left, input t_feat right);
        t_pixel_pair px;
        px.row_start = rs;
        px.left      = left;
        px.right     = right;
        send_request(px);
    endtask

    // Stop sending and wait until every outstanding result has come back, then let the
    // block settle. Called straight after an acceptance, so valid has no other update here.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (board.pending_disparities.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // All three registers, back to back; only called with the block idle.
    task automatic apply_settings(input int grad_w, input int dog_w, input int range_val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_WEIGHT_GRAD;
        i_cfg_data <= CFG_DATA_W'(grad_w);
        @(posedge i_clk);
        board.write_register(CFG_WEIGHT_GRAD, CFG_DATA_W'(grad_w));
        i_cfg_addr <= CFG_WEIGHT_DOG;
        i_cfg_data <= CFG_DATA_W'(dog_w);
        @(posedge i_clk);
        board.write_register(CFG_WEIGHT_DOG, CFG_DATA_W'(dog_w));
        i_cfg_addr <= CFG_DISP_RANGE;
        i_cfg_data <= CFG_DATA_W'(range_val);
        @(posedge i_clk);
        board.write_register(CFG_DISP_RANGE, CFG_DATA_W'(range_val));
        i_cfg_we <= 1'b0;
    endtask

    // One row of pixels. Most rows are stereo-like: the left pixel repeats a right pixel
    // up to lim - 1 columns back (with jitter), so the cost curve has a real minimum. The rest are
    // uncorrelated noise, and some rows carry no row-start flag and so continue the last.
    // A row never runs past what is left of the phase quota.
    task automatic send_random_row(input int unsigned lim, input int unsigned max_len);
        t_feat       row_right[$];
        t_pixel_pair px;
        int unsigned len, shift, pick, c;
        bit          correlated;
        bit          marked;
        pick = $urandom_range(0, 99);
        if (pick < 60)      len = $urandom_range(1, 16);
        else if (pick < 85) len = $urandom_range(17, 63);
        else                len = $urandom_range(64, 120);   // column saturates
        if (len > max_len) len = max_len;
        shift      = $urandom_range(0, lim - 1);
        correlated = ($urandom_range(0, 99) < 85);
        marked     = ($urandom_range(0, 9) != 0);
        for (c = 0; c < len; c++) begin
            px.row_start = (c == 0) && marked;
            px.right     = random_feat();
            row_right.push_back(px.right);
            if ($urandom_range(0, 15) == 0) shift = $urandom_range(0, lim - 1);
            if (correlated && c >= shift && $urandom_range(0, 9) != 0)
                px.left = jitter_feat(row_right[c - shift], $urandom_range(0, 8));
            else
                px.left = random_feat();
            send_request(px);
            // occasional full drain in mid-row
            if ($urandom_range(0, 299) == 0) wait_for_drain();
        end
    endtask

    task automatic run_phase(input int grad_w, input int dog_w, input int range_val,
                             input int unsigned quota, input bit steady);
        int unsigned first, lim;
        wait_for_drain();
        apply_settings(grad_w, dog_w, range_val);
        no_idle = steady;
        lim = (range_val < 1) ? 1 : (range_val > WINDOW_DEPTH) ? WINDOW_DEPTH : range_val;
        first = sent_count;
        while (sent_count - first < quota)
            send_random_row(lim, quota - (sent_count - first));
        no_idle = 1'b0;
    endtask

    // Result side: random back-pressure, every accepted result checked in order.
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = idle_gap();
            end
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) board.check_result(o_disparity, o_whole_disparity);
        end
    end

    // Watchdog: far above the slowest legal run of about 700 requests.
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int i;
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset register values.
        // First request after reset without a row start: taken as column 0.
        send_pixel(1'b0, flat_feat(8'hFF), flat_feat(8'h00));
        send_pixel(1'b0, flat_feat(8'h00), flat_feat(8'hFF));
        // Identical pixels: every cost equal, the smallest disparity must win.
        for (i = 0; i < 5; i++) send_pixel(i == 0, flat_feat(8'h80), flat_feat(8'h80));
        // Ramp with the match three columns back, offset so the parabola is asymmetric.
        for (i = 0; i < 8; i++)
            send_pixel(i == 0, (i >= 3) ? flat_feat(8'((i - 3) * 20 + 7)) : flat_feat(8'h00),
                       flat_feat(8'(i * 20)));
        // Winner at the last searched disparity: no refinement.
        send_pixel(1'b1, flat_feat(8'h00), flat_feat(8'h00));
        send_pixel(1'b0, flat_feat(8'h00), flat_feat(8'hC8));
        // Mixed extremes across the four features.
        send_pixel(1'b1, '{dog_y: 8'h00, dog_x: 8'hFF, grad_y: 8'h00, grad_x: 8'hFF},
                   '{dog_y: 8'hFF, dog_x: 8'h00, grad_y: 8'hFF, grad_x: 8'h00});
        send_pixel(1'b0, '{dog_y: 8'hFF, dog_x: 8'h00, grad_y: 8'hFF, grad_x: 8'h00},
                   '{dog_y: 8'h00, dog_x: 8'hFF, grad_y: 8'h00, grad_x: 8'hFF});

        // Random part over several settings: weight extremes, range 1, range 0 (acts as 1),
        // range above the window (acts as the full window), small and full ranges.
        run_phase(4095, 4095, 64, 110, 1'b0);
        run_phase(0, 0, 1, 40, 1'b0);
        run_phase(4095, 0, 0, 30, 1'b0);
        run_phase(0, 4095, 127, 90, 1'b0);
        run_phase($urandom_range(1, 4095), $urandom_range(1, 4095), 2, 60, 1'b0);
        run_phase($urandom_range(1, 4095), $urandom_range(1, 4095), $urandom_range(3, 63),
                  110, 1'b1);
        run_phase($urandom_range(1, 4095), $urandom_range(1, 4095), 64, 240, 1'b0);

        wait_for_drain();
        if (board.error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
